>>> rtl/core/pig_pkg.sv
// Shared constants, types and helpers of the prime implicant generator.
package pig_pkg;

    localparam int NUM_VARS   = 8;
    localparam int MAX_PRIMES = 1024;
    localparam int TERM_CNT   = 1 << NUM_VARS;
    localparam int CUBE_AW    = 2 * NUM_VARS;
    localparam int CUBE_DEPTH = 1 << CUBE_AW;
    localparam int PRIME_AW   = $clog2(MAX_PRIMES);
    localparam int PRIME_W    = 2 * NUM_VARS;
    localparam int CNT_W      = $clog2(MAX_PRIMES + 1);
    localparam int BIT_W      = $clog2(NUM_VARS + 1);
    localparam int KIND_W     = 2;
    localparam int TERM_W     = 8;
    localparam int TV_W       = 2;
    localparam int FIELD_W    = 8;
    localparam int COUNT_W    = 11;

    typedef logic [NUM_VARS-1:0] t_vars;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_FETCH = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    localparam logic [TV_W-1:0] TV_TRUE      = 2'd1;
    localparam logic [TV_W-1:0] TV_DONT_CARE = 2'd2;

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_RUN_OUT,
        T_FETCH_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GEN_ISSUE,
        S_GEN_RDB,
        S_GEN_WR,
        S_PR_ISSUE,
        S_PR_PRES,
        S_PR_NISSUE,
        S_PR_NCHK
    } t_srch_state;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] total;
    } t_srch_stat;

    typedef struct packed {
        logic                en;
        logic [PRIME_AW-1:0] addr;
        logic [PRIME_W-1:0]  data;
    } t_prime_wr;

    // one-hot of the highest set bit, zero for an empty mask
    function automatic t_vars top_bit(input t_vars m);
        t_vars r;
        r = '0;
        for (int i = 0; i < NUM_VARS; i++) begin
            if (m[i]) begin
                r = t_vars'(1) << i;
            end
        end
        return r;
    endfunction

    // Next dash mask in preorder of ascending position lists; MSB flags the end.
    function automatic logic [NUM_VARS:0] next_mask(input t_vars m);
        t_vars h;
        t_vars m2;
        t_vars h2;
        h  = top_bit(m);
        m2 = m & ~h;
        h2 = top_bit(m2);
        if (m == '0) begin
            return {1'b0, t_vars'(1)};
        end
        if (!h[NUM_VARS-1]) begin
            return {1'b0, m | (h << 1)};
        end
        if (m2 == '0) begin
            return {1'b1, t_vars'(0)};
        end
        return {1'b0, (m2 & ~h2) | (h2 << 1)};
    endfunction

endpackage

>>> rtl/core/pig_in_if.sv
// Input channel of the prime implicant generator.
interface pig_in_if import pig_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TERM_W-1:0] term;
    logic [TV_W-1:0]   term_value;

    modport source (output valid, kind, term, term_value, input ready);
    modport sink   (input valid, kind, term, term_value, output ready);
endinterface

>>> rtl/core/pig_out_if.sv
// Result channel of the prime implicant generator.
interface pig_out_if import pig_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] prime_value;
    logic [FIELD_W-1:0] prime_mask;
    logic [COUNT_W-1:0] prime_count;
    logic               valid_res;
    logic               last;

    modport source (output valid, prime_value, prime_mask, prime_count, valid_res, last,
                    input ready);
    modport sink   (input valid, prime_value, prime_mask, prime_count, valid_res, last,
                    output ready);
endinterface

>>> rtl/core/pig_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> rtl/core/pig_search.sv
// Run sequencer: builds the implicant store, then walks it for primes in list order.
module pig_search import pig_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [TERM_CNT-1:0] i_marks,
    output t_srch_stat          o_stat,
    output t_prime_wr           o_wr
);
    t_srch_state      r_state, n_state;
    t_vars            r_m, n_m;
    t_vars            r_v, n_v;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_pa, n_pa;
    logic [CNT_W-1:0] r_total, n_total;
    logic             r_done, n_done;

    logic               cube_we, cube_wd, cube_re, cube_rd;
    logic [CUBE_AW-1:0] cube_wa, cube_ra;

    t_vars             lowb, rest, nb;
    logic              overlap, gen_adv, pr_adv;
    logic [NUM_VARS:0] nxt;

    pig_ram #(.WIDTH(1), .DEPTH(CUBE_DEPTH)) u_cube_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cube_we),
        .i_wr_addr (cube_wa),
        .i_wr_data (cube_wd),
        .i_rd_en   (cube_re),
        .i_rd_addr (cube_ra),
        .o_rd_data (cube_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_done  <= n_done;
        end
        r_m   <= n_m;
        r_v   <= n_v;
        r_bit <= n_bit;
        r_pa  <= n_pa;
    end

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_v     = r_v;
        n_bit   = r_bit;
        n_pa    = r_pa;
        n_total = r_total;
        n_done  = 1'b0;
        gen_adv = 1'b0;
        pr_adv  = 1'b0;
        cube_we = 1'b0;
        cube_wd = 1'b0;
        cube_wa = {r_m, r_v};
        cube_re = 1'b0;
        cube_ra = {r_m, r_v};
        lowb    = r_m & (~r_m + t_vars'(1));
        rest    = r_m ^ lowb;
        nb      = t_vars'(1) << r_bit;
        overlap = |(r_v & r_m);
        nxt     = next_mask(r_m);
        o_wr.en   = 1'b0;
        o_wr.addr = r_total[PRIME_AW-1:0];
        o_wr.data = {r_m, r_v};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_m     = '0;
                    n_v     = '0;
                    n_total = '0;
                    n_state = S_GEN_ISSUE;
                end
            end
            S_GEN_ISSUE: begin
                if (overlap) begin
                    gen_adv = 1'b1;
                end else if (r_m == '0) begin
                    cube_we = 1'b1;
                    cube_wd = i_marks[r_v];
                    gen_adv = 1'b1;
                end else begin
                    cube_re = 1'b1;
                    cube_ra = {rest, r_v};
                    n_state = S_GEN_RDB;
                end
            end
            S_GEN_RDB: begin
                n_pa    = cube_rd;
                cube_re = 1'b1;
                cube_ra = {rest, r_v | lowb};
                n_state = S_GEN_WR;
            end
            S_GEN_WR: begin
                cube_we = 1'b1;
                cube_wd = r_pa & cube_rd;
                n_state = S_GEN_ISSUE;
                gen_adv = 1'b1;
            end
            S_PR_ISSUE: begin
                if (overlap) begin
                    pr_adv = 1'b1;
                end else begin
                    cube_re = 1'b1;
                    n_state = S_PR_PRES;
                end
            end
            S_PR_PRES: begin
                if (!cube_rd) begin
                    pr_adv = 1'b1;
                end else begin
                    n_bit   = '0;
                    n_state = S_PR_NISSUE;
                end
            end
            S_PR_NISSUE: begin
                if (r_bit == BIT_W'(NUM_VARS)) begin
                    // no neighbour with one more dash exists: prime
                    if (r_total < CNT_W'(MAX_PRIMES)) begin
                        o_wr.en = 1'b1;
                        n_total = r_total + CNT_W'(1);
                    end
                    pr_adv = 1'b1;
                end else if ((r_m & nb) != '0) begin
                    n_bit = r_bit + BIT_W'(1);
                end else begin
                    cube_re = 1'b1;
                    cube_ra = {r_m | nb, r_v & ~nb};
                    n_state = S_PR_NCHK;
                end
            end
            S_PR_NCHK: begin
                if (cube_rd) begin
                    pr_adv = 1'b1;
                end else begin
                    n_bit   = r_bit + BIT_W'(1);
                    n_state = S_PR_NISSUE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // build order: masks ascending, values within
        if (gen_adv) begin
            if (r_v == '1) begin
                n_v = '0;
                if (r_m == '1) begin
                    n_m     = '0;
                    n_state = S_PR_ISSUE;
                end else begin
                    n_m = r_m + t_vars'(1);
                end
            end else begin
                n_v = r_v + t_vars'(1);
            end
        end

        // output order: first minterm, then dash positions in preorder
        if (pr_adv) begin
            if (nxt[NUM_VARS]) begin
                n_m = '0;
                if (r_v == '1) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_v     = r_v + t_vars'(1);
                    n_state = S_PR_ISSUE;
                end
            end else begin
                n_m     = nxt[NUM_VARS-1:0];
                n_state = S_PR_ISSUE;
            end
        end
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.done  = r_done;
    assign o_stat.total = r_total;

`ifndef SYNTHESIS
    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_PRIMES))
        else $error("prime total beyond capacity");
    a_wr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |=> (r_total == $past(r_total) + CNT_W'(1)))
        else $error("prime write without count step");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("done raised while still searching");
`endif
endmodule

>>> rtl/core/prime_implicant_generator_top.sv
// Top level: handshakes, term marks, prime list store, fetch and result register.
// Load and clear stay idle; fetch does one prime list read, then waits for the result slot.
// Run builds the cube store, then searches it for primes, through the store's single read port.
// One item at a time; the result register lets the next item in while a beat waits.
// Reset clears marks, prime count and fetch pointer; the cube and prime stores are not cleared.
module prime_implicant_generator_top import pig_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pig_in_if.sink   i_item,
    pig_out_if.source o_res
);
    t_top_state          r_state, n_state;
    logic [TERM_CNT-1:0] r_marks, n_marks;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [CNT_W-1:0]    r_ptr, n_ptr;
    logic                r_hit, n_hit;
    logic                r_ov, n_ov;
    logic [FIELD_W-1:0]  r_value, n_value;
    logic [FIELD_W-1:0]  r_mask, n_mask;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_vres, n_vres;
    logic                r_last, n_last;

    logic               accept, slot_free, start, prd_en;
    logic [PRIME_W-1:0] prime_rd;
    t_srch_stat         stat;
    t_prime_wr          pwr;

    pig_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_marks (r_marks),
        .o_stat  (stat),
        .o_wr    (pwr)
    );

    pig_ram #(.WIDTH(PRIME_W), .DEPTH(MAX_PRIMES)) u_prime_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pwr.en),
        .i_wr_addr (pwr.addr),
        .i_wr_data (pwr.data),
        .i_rd_en   (prd_en),
        .i_rd_addr (r_ptr[PRIME_AW-1:0]),
        .o_rd_data (prime_rd)
    );

    assign i_item.ready = (r_state == T_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign slot_free    = !r_ov || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_marks <= '0;
            r_total <= '0;
            r_ptr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_marks <= n_marks;
            r_total <= n_total;
            r_ptr   <= n_ptr;
            r_ov    <= n_ov;
        end
        r_hit   <= n_hit;
        r_value <= n_value;
        r_mask  <= n_mask;
        r_count <= n_count;
        r_vres  <= n_vres;
        r_last  <= n_last;
    end

    always_comb begin
        n_state = r_state;
        n_marks = r_marks;
        n_total = r_total;
        n_ptr   = r_ptr;
        n_hit   = r_hit;
        n_ov    = r_ov && !o_res.ready;
        n_value = r_value;
        n_mask  = r_mask;
        n_count = r_count;
        n_vres  = r_vres;
        n_last  = r_last;
        start   = 1'b0;
        prd_en  = 1'b0;

        case (r_state)
            T_IDLE: begin
                if (accept) begin
                    case (t_kind'(i_item.kind))
                        KIND_LOAD: begin
                            if (i_item.term_value inside {TV_TRUE, TV_DONT_CARE}) begin
                                n_marks[i_item.term[NUM_VARS-1:0]] = 1'b1;
                            end
                        end
                        KIND_RUN: begin
                            start   = 1'b1;
                            n_total = '0;
                            n_ptr   = '0;
                            n_state = T_RUN;
                        end
                        KIND_FETCH: begin
                            prd_en  = 1'b1;
                            n_hit   = (r_ptr < r_total);
                            n_state = T_FETCH_OUT;
                        end
                        KIND_CLEAR: begin
                            n_marks = '0;
                            n_total = '0;
                            n_ptr   = '0;
                        end
                        default: begin
                            n_state = T_IDLE;
                        end
                    endcase
                end
            end
            T_RUN: begin
                if (stat.done) begin
                    n_total = stat.total;
                    n_state = T_RUN_OUT;
                end
            end
            T_RUN_OUT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_value = '0;
                    n_mask  = '0;
                    n_count = COUNT_W'(r_total);
                    n_vres  = 1'b0;
                    n_last  = 1'b0;
                    n_state = T_IDLE;
                end
            end
            T_FETCH_OUT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_count = COUNT_W'(r_total);
                    n_state = T_IDLE;
                    if (r_hit) begin
                        n_value = FIELD_W'(prime_rd[NUM_VARS-1:0]);
                        n_mask  = FIELD_W'(prime_rd[PRIME_W-1:NUM_VARS]);
                        n_vres  = 1'b1;
                        n_last  = ((r_ptr + CNT_W'(1)) == r_total);
                        n_ptr   = r_ptr + CNT_W'(1);
                    end else begin
                        n_value = '0;
                        n_mask  = '0;
                        n_vres  = 1'b0;
                        n_last  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    assign o_res.valid       = r_ov;
    assign o_res.prime_value = r_value;
    assign o_res.prime_mask  = r_mask;
    assign o_res.prime_count = r_count;
    assign o_res.valid_res   = r_vres;
    assign o_res.last        = r_last;

`ifndef SYNTHESIS
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_total)
        else $error("fetch pointer past prime count");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.kind == KIND_CLEAR)) |=> ((r_total == '0) && (r_ptr == '0)))
        else $error("clear did not reset count and pointer");
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_vres) |-> (r_count != '0))
        else $error("prime beat with zero count");
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> stat.busy)
        else $error("search did not start");
`endif
endmodule

>>> test/tb.sv
// Testbench for the prime implicant generator: table-driven directed items, then random phases.
`timescale 1ns / 1ps

module tb;
    import pig_pkg::*;

    localparam int IDLE_LIMIT = 1000000;
    localparam int ITEM_GOAL  = 950;

    typedef struct packed {
        logic [7:0]  value;
        logic [7:0]  mask;
        logic [10:0] count;
        logic        vres;
        logic        last;
    } t_prime_beat;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  term;
        logic [1:0]  tv;
        logic        typed;
        t_prime_beat res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    pig_in_if  in_ch ();
    pig_out_if out_ch ();

    prime_implicant_generator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch),
        .o_res   (out_ch)
    );

    // shadow state of the block
    logic [1:0]  mark_tab [TERM_CNT];
    logic        implicant [65536];
    logic [15:0] prime_tab [MAX_PRIMES];
    int          prime_cnt;
    int          fetch_idx;

    t_prime_beat beats_due [$];
    int          fails;
    int          idle_cycles;
    int          n_items;
    int          n_runs;
    int          n_beats;
    logic        rx_steady;
    logic        tx_steady;
    int          rx_stall;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int ones8(input logic [7:0] x);
        int c;
        c = 0;
        for (int i = 0; i < 8; i++) c += x[i];
        return c;
    endfunction

    function automatic logic [7:0] spread_bits(input int k, input logic [7:0] m);
        logic [7:0] r;
        int         j;
        r = '0;
        j = 0;
        for (int i = 0; i < 8; i++) begin
            if (m[i]) begin
                r[i] = k[j];
                j++;
            end
        end
        return r;
    endfunction

    // compares ascending minterm lists of two cubes, {mask, value}
    function automatic logic list_before(input logic [15:0] a, input logic [15:0] b);
        int         na;
        int         nb;
        int         n;
        logic [7:0] ta;
        logic [7:0] tb2;
        na = 1 << ones8(a[15:8]);
        nb = 1 << ones8(b[15:8]);
        n  = (na < nb) ? na : nb;
        for (int k = 0; k < n; k++) begin
            ta  = a[7:0] | spread_bits(k, a[15:8]);
            tb2 = b[7:0] | spread_bits(k, b[15:8]);
            if (ta != tb2) return ta < tb2;
        end
        return na < nb;
    endfunction

    function automatic void add_prime(input logic [15:0] p);
        int lo;
        int hi;
        int mid;
        int top;
        lo = 0;
        hi = prime_cnt;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (list_before(p, prime_tab[mid])) hi = mid;
            else lo = mid + 1;
        end
        if (lo >= MAX_PRIMES) return;
        top = (prime_cnt < MAX_PRIMES) ? prime_cnt : MAX_PRIMES - 1;
        for (int i = top; i > lo; i--) prime_tab[i] = prime_tab[i-1];
        prime_tab[lo] = p;
        if (prime_cnt < MAX_PRIMES) prime_cnt++;
    endfunction

    function automatic void find_primes();
        logic [7:0] m;
        logic [7:0] v;
        logic [7:0] b;
        logic [7:0] rest;
        logic       is_prime;
        prime_cnt = 0;
        fetch_idx = 0;
        for (int mi = 0; mi < 256; mi++) begin
            for (int vi = 0; vi < 256; vi++) begin
                m = 8'(mi);
                v = 8'(vi);
                if ((v & m) == 0) begin
                    if (m == 0) begin
                        implicant[{m, v}] = mark_tab[v] != 0;
                    end else begin
                        b    = m & (~m + 8'd1);
                        rest = m ^ b;
                        implicant[{m, v}] = implicant[{rest, v}] && implicant[{rest, v | b}];
                    end
                end
            end
        end
        for (int mi = 0; mi < 256; mi++) begin
            for (int vi = 0; vi < 256; vi++) begin
                m = 8'(mi);
                v = 8'(vi);
                if ((v & m) == 0 && implicant[{m, v}]) begin
                    is_prime = 1'b1;
                    for (int i = 0; i < 8; i++) begin
                        b = 8'd1 << i;
                        if ((m & b) == 0 && implicant[{m | b, v & ~b}]) is_prime = 1'b0;
                    end
                    if (is_prime) add_prime({m, v});
                end
            end
        end
    endfunction

    // updates the shadow state for one accepted item and returns the beat it causes
    function automatic logic predict_item(input t_kind kind, input logic [7:0] term,
                                          input logic [1:0] tv, output t_prime_beat r);
        r = '0;
        case (kind)
            KIND_LOAD: begin
                if ((tv == TV_TRUE || tv == TV_DONT_CARE) && mark_tab[term] == 0)
                    mark_tab[term] = tv;
                return 1'b0;
            end
            KIND_CLEAR: begin
                for (int i = 0; i < TERM_CNT; i++) mark_tab[i] = '0;
                prime_cnt = 0;
                fetch_idx = 0;
                return 1'b0;
            end
            KIND_RUN: begin
                find_primes();
            end
            default: begin
                if (fetch_idx < prime_cnt) begin
                    r.value = prime_tab[fetch_idx][7:0];
                    r.mask  = prime_tab[fetch_idx][15:8];
                    r.vres  = 1'b1;
                    r.last  = (fetch_idx + 1 == prime_cnt);
                    fetch_idx++;
                end
            end
        endcase
        r.count = 11'(prime_cnt);
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int d;
        d = $urandom_range(0, 99);
        if (d < 55) return 0;
        if (d < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(input t_kind kind, input logic [7:0] term, input logic [1:0] tv,
                             input logic typed, input t_prime_beat typed_res);
        int          gap;
        t_prime_beat r;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.term       <= term;
        in_ch.term_value <= tv;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_items++;
        if (kind == KIND_RUN) n_runs++;
        if (predict_item(kind, term, tv, r)) begin
            if (typed && r != typed_res) begin
                $error("typed row disagrees with predictor: %h vs %h", typed_res, r);
                fails++;
            end
            beats_due = {beats_due, r};
        end
    endtask

    task automatic drain_beats();
        in_ch.valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
    endtask

    // result side: random back-pressure and checking
    always @(posedge i_clk) begin
        t_prime_beat want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_stall     <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_beats++;
                if (beats_due.size() == 0) begin
                    $error("unexpected result beat");
                    fails++;
                end else begin
                    want = beats_due.pop_front();
                    if (out_ch.prime_value !== want.value) begin
                        $error("prime_value exp %h got %h", want.value, out_ch.prime_value);
                        fails++;
                    end
                    if (out_ch.prime_mask !== want.mask) begin
                        $error("prime_mask exp %h got %h", want.mask, out_ch.prime_mask);
                        fails++;
                    end
                    if (out_ch.prime_count !== want.count) begin
                        $error("prime_count exp %0d got %0d", want.count, out_ch.prime_count);
                        fails++;
                    end
                    if (out_ch.valid_res !== want.vres) begin
                        $error("valid_res exp %b got %b", want.vres, out_ch.valid_res);
                        fails++;
                    end
                    if (out_ch.last !== want.last) begin
                        $error("last exp %b got %b", want.last, out_ch.last);
                        fails++;
                    end
                end
            end
            if (rx_steady) begin
                out_ch.ready <= 1'b1;
            end else if (rx_stall > 0) begin
                out_ch.ready <= 1'b0;
                rx_stall     <= rx_stall - 1;
            end else begin
                out_ch.ready <= 1'b1;
                rx_stall     <= pick_gap();
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    t_dir_row dir_tab [22];

    initial begin
        int          nl;
        int          nf;
        int          d;
        logic [1:0]  tv;
        t_prime_beat zero_beat;
        zero_beat = '0;
        fails = 0; n_items = 0; n_runs = 0; n_beats = 0;
        rx_steady = 1'b0; tx_steady = 1'b0;
        prime_cnt = 0; fetch_idx = 0;
        for (int i = 0; i < TERM_CNT; i++) mark_tab[i] = '0;

        dir_tab[0]  = '{KIND_FETCH, 8'd0,   2'd0, 1'b1, '0};  // fetch before any run
        dir_tab[1]  = '{KIND_RUN,   8'd0,   2'd0, 1'b1, '0};  // nothing marked
        dir_tab[2]  = '{KIND_FETCH, 8'd0,   2'd0, 1'b1, '0};
        dir_tab[3]  = '{KIND_LOAD,  8'd0,   2'd0, 1'b0, '0};  // false: ignored
        dir_tab[4]  = '{KIND_LOAD,  8'd255, 2'd3, 1'b0, '0};  // unknown value: ignored
        dir_tab[5]  = '{KIND_LOAD,  8'd0,   2'd1, 1'b0, '0};
        dir_tab[6]  = '{KIND_LOAD,  8'd1,   2'd2, 1'b0, '0};
        dir_tab[7]  = '{KIND_LOAD,  8'd1,   2'd1, 1'b0, '0};  // first marking wins
        dir_tab[8]  = '{KIND_LOAD,  8'd255, 2'd1, 1'b0, '0};
        dir_tab[9]  = '{KIND_LOAD,  8'd254, 2'd2, 1'b0, '0};
        dir_tab[10] = '{KIND_LOAD,  8'd128, 2'd1, 1'b0, '0};
        dir_tab[11] = '{KIND_RUN,   8'd0,   2'd0, 1'b0, '0};
        for (int i = 12; i < 17; i++) dir_tab[i] = '{KIND_FETCH, 8'd0, 2'd0, 1'b0, '0};
        dir_tab[17] = '{KIND_LOAD,  8'd2,   2'd1, 1'b0, '0};  // list unchanged until next run
        dir_tab[18] = '{KIND_FETCH, 8'd0,   2'd0, 1'b0, '0};
        dir_tab[19] = '{KIND_CLEAR, 8'd0,   2'd0, 1'b0, '0};
        dir_tab[20] = '{KIND_FETCH, 8'd0,   2'd0, 1'b1, '0};
        dir_tab[21] = '{KIND_RUN,   8'd0,   2'd0, 1'b1, '0};

        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.kind       <= KIND_LOAD;
        in_ch.term       <= '0;
        in_ch.term_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].kind, dir_tab[i].term, dir_tab[i].tv,
                      dir_tab[i].typed, dir_tab[i].res);

        while (n_items < ITEM_GOAL) begin
            // sender holds off until every result of the last phase is in
            drain_beats();
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0)
                send_item(KIND_CLEAR, 8'($urandom), 2'd0, 1'b0, zero_beat);
            nl = ($urandom_range(0, 2) == 0) ? $urandom_range(100, 180) : $urandom_range(5, 60);
            for (int i = 0; i < nl && n_items < ITEM_GOAL - 2; i++) begin
                d = $urandom_range(0, 99);
                if (d < 4) begin
                    send_item(KIND_FETCH, 8'($urandom), 2'($urandom), 1'b0, zero_beat);
                end else begin
                    tv = (d < 15) ? (($urandom_range(0, 1) == 0) ? 2'd0 : 2'd3)
                                  : 2'($urandom_range(1, 2));
                    send_item(KIND_LOAD, 8'($urandom), tv, 1'b0, zero_beat);
                end
            end
            send_item(KIND_RUN, 8'($urandom), 2'($urandom), 1'b0, zero_beat);
            nf = prime_cnt + $urandom_range(0, 3);
            for (int i = 0; i < nf && n_items < ITEM_GOAL; i++)
                send_item(KIND_FETCH, 8'($urandom), 2'($urandom), 1'b0, zero_beat);
        end

        drain_beats();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d items with %0d searches and %0d result beats,", n_items, n_runs,
                 n_beats);
        $display("including ignored loads, repeat marks, exhausted fetches and clears.");
        if (fails == 0 && beats_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
